// File: rtl/cnlc_pkg.sv
// ----------------------------------------------------------------------------
// cnlc_pkg: shared types and helpers for the card number classifier
// Holds the verdict codes, length limits, digit helpers and the handoff
// struct between the input register and the accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package cnlc_pkg;

	localparam int DIGIT_W = 4;
	localparam int COUNT_W = 5;
	localparam int SUM_W   = 4;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd17;
	localparam logic [COUNT_W-1:0] LEN_13    = 5'd13;
	localparam logic [COUNT_W-1:0] LEN_15    = 5'd15;
	localparam logic [COUNT_W-1:0] LEN_16    = 5'd16;

	typedef enum logic [1:0] {
		VERDICT_INVALID = 2'd0,
		VERDICT_CLASS_A = 2'd1,  // prefix 34 or 37, length 15
		VERDICT_CLASS_B = 2'd2,  // prefix 51 to 55, length 16
		VERDICT_CLASS_C = 2'd3   // prefix 4, length 13 or 16
	} verdict_t;

	// Input register contents handed to the accumulator.
	typedef struct packed {
		logic                valid;
		logic                last;
		logic [DIGIT_W-1:0]  digit;
	} in_stage_t;

	// Luhn doubling: digits 0 to 9 map to the digit sum of twice the digit; every 4-bit code has an entry.
	function automatic logic [SUM_W-1:0] luhn_double(input logic [DIGIT_W-1:0] d);
		logic [SUM_W-1:0] r;
		unique case (d)
			4'd0:  r = 4'd0;
			4'd1:  r = 4'd2;
			4'd2:  r = 4'd4;
			4'd3:  r = 4'd6;
			4'd4:  r = 4'd8;
			4'd5:  r = 4'd1;
			4'd6:  r = 4'd3;
			4'd7:  r = 4'd5;
			4'd8:  r = 4'd7;
			4'd9:  r = 4'd9;
			4'd10: r = 4'd1;
			4'd11: r = 4'd3;
			4'd12: r = 4'd5;
			4'd13: r = 4'd7;
			4'd14: r = 4'd9;
			default: r = 4'd1;  // 15 maps to 1, like 5 and 10
		endcase
		return r;
	endfunction

	// Digit value reduced mod 10.
	function automatic logic [SUM_W-1:0] plain_mod10(input logic [DIGIT_W-1:0] d);
		return (d >= 4'd10) ? d - 4'd10 : d;
	endfunction

	// Sum of two values below 10, reduced mod 10.
	function automatic logic [SUM_W-1:0] add_mod10(input logic [SUM_W-1:0] a,
			input logic [SUM_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= 5'd10) begin
			s = s - 5'd10;
		end
		return s[SUM_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: rtl/cnlc_in_reg.sv
// ----------------------------------------------------------------------------
// cnlc_in_reg: input register of the card number classifier
// Captures one digit transaction and holds it until the next stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module cnlc_in_reg (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [cnlc_pkg::DIGIT_W-1:0] digit,
	input  wire logic                       last_digit,
	input  wire logic                       advance,
	output cnlc_pkg::in_stage_t             stage
);
	import cnlc_pkg::*;

	logic               valid_s1;
	logic               last_s1;
	logic [DIGIT_W-1:0] digit_s1;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			last_s1  <= last_digit;
			digit_s1 <= digit;
		end
	end

	assign stage = '{valid: valid_s1, last: last_s1, digit: digit_s1};

endmodule

`default_nettype wire

// File: rtl/cnlc_accum.sv
// ----------------------------------------------------------------------------
// cnlc_accum: digit accumulator and classifier
// Keeps the count, the two Luhn sums and the prefix digits, and works out
// the verdict for the number that ends with the current digit.
// ----------------------------------------------------------------------------
`default_nettype none

module cnlc_accum (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire cnlc_pkg::in_stage_t          stage,
	input  wire logic                         advance,
	output cnlc_pkg::verdict_t                verdict_next,
	output logic [cnlc_pkg::COUNT_W-1:0]      total_next
);
	import cnlc_pkg::*;

	logic [COUNT_W-1:0] count_q;
	logic [SUM_W-1:0]   sum_even_q;
	logic [SUM_W-1:0]   sum_odd_q;
	logic [DIGIT_W-1:0] first_q;
	logic [DIGIT_W-1:0] second_q;

	logic [COUNT_W-1:0] count_d;
	logic [SUM_W-1:0]   sum_even_d;
	logic [SUM_W-1:0]   sum_odd_d;
	logic [DIGIT_W-1:0] first_d;
	logic [DIGIT_W-1:0] second_d;
	logic [SUM_W-1:0]   dbl;
	logic [SUM_W-1:0]   plain;
	logic [SUM_W-1:0]   luhn;
	logic               len_ok;

	always_comb begin
		dbl   = luhn_double(stage.digit);
		plain = plain_mod10(stage.digit);

		// An even count means this digit sits at an odd position.
		if (!count_q[0]) begin
			sum_even_d = add_mod10(sum_even_q, dbl);
			sum_odd_d  = add_mod10(sum_odd_q, plain);
		end else begin
			sum_even_d = add_mod10(sum_even_q, plain);
			sum_odd_d  = add_mod10(sum_odd_q, dbl);
		end

		first_d  = (count_q == 5'd0) ? stage.digit : first_q;
		second_d = (count_q == 5'd1) ? stage.digit : second_q;
		count_d  = (count_q < COUNT_MAX) ? count_q + 5'd1 : count_q;

		luhn   = count_d[0] ? sum_odd_d : sum_even_d;
		len_ok = (count_d == LEN_13) || (count_d == LEN_15) || (count_d == LEN_16);

		priority if (!len_ok || luhn != 4'd0) begin
			verdict_next = VERDICT_INVALID;
		end else if (count_d == LEN_15 && first_d == 4'd3
				&& (second_d == 4'd4 || second_d == 4'd7)) begin
			verdict_next = VERDICT_CLASS_A;
		end else if (count_d == LEN_16 && first_d == 4'd5
				&& second_d >= 4'd1 && second_d <= 4'd5) begin
			verdict_next = VERDICT_CLASS_B;
		end else if ((count_d == LEN_13 || count_d == LEN_16) && first_d == 4'd4) begin
			verdict_next = VERDICT_CLASS_C;
		end else begin
			verdict_next = VERDICT_INVALID;
		end

		total_next = count_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			sum_even_q <= '0;
			sum_odd_q  <= '0;
			first_q    <= '0;
			second_q   <= '0;
		end else if (advance) begin
			if (stage.last) begin
				count_q    <= '0;
				sum_even_q <= '0;
				sum_odd_q  <= '0;
				first_q    <= '0;
				second_q   <= '0;
			end else begin
				count_q    <= count_d;
				sum_even_q <= sum_even_d;
				sum_odd_q  <= sum_odd_d;
				first_q    <= first_d;
				second_q   <= second_d;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/card_number_luhn_classifier.sv
// ----------------------------------------------------------------------------
// card_number_luhn_classifier: Luhn check and issuer class of a card number
// Digits enter one per transaction on the input channel, most significant
// first, with last_digit set on the final one. The input channel is a
// valid/ready pair carrying digit and last_digit.
// Each digit is captured in an input register and folded into the running
// count, Luhn sums and prefix digits once it moves on. Only the final
// digit of a number yields an output transaction, carrying the verdict and
// the saturating digit count; it leaves from an output register that is
// loaded from the input register when the final digit moves on.
// Throughput is one digit per cycle while no final digit waits on a pending
// result. A digit that does not end a number never waits on the output
// side. When the receiver stalls with a result pending, a final digit waits
// in the input register and the input channel backs up behind it.
// Reset (arst_n low, asynchronous) empties both registers and clears the
// accumulated state; the state also clears after each number's verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module card_number_luhn_classifier (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [cnlc_pkg::DIGIT_W-1:0] digit,
	input  wire logic                         last_digit,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [1:0]                        verdict,
	output logic [cnlc_pkg::COUNT_W-1:0]      digit_total
);
	import cnlc_pkg::*;

	in_stage_t          stage;
	logic               advance;
	verdict_t           verdict_next;
	logic [COUNT_W-1:0] total_next;

	logic               out_valid_q;
	verdict_t           verdict_q;
	logic [COUNT_W-1:0] total_q;

	// A digit moves on unless it ends a number and the result slot is
	// still occupied by a result the receiver has not taken.
	assign advance = stage.valid && (!stage.last || !out_valid_q || out_ready);

	cnlc_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.digit      (digit),
		.last_digit (last_digit),
		.advance    (advance),
		.stage      (stage)
	);

	cnlc_accum u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.stage        (stage),
		.advance      (advance),
		.verdict_next (verdict_next),
		.total_next   (total_next)
	);

	// Output register: filled by a final digit, emptied when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && stage.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && stage.last) begin
			verdict_q <= verdict_next;
			total_q   <= total_next;
		end
	end

	assign out_valid   = out_valid_q;
	assign verdict     = verdict_q;
	assign digit_total = total_q;

endmodule

`default_nettype wire
